// ===== rtl/hbr_pkg.sv =====
// hbr_pkg: shared types, constants and character helpers for the byte range parser
// used by hbr_parse, hbr_resolve and http_byte_range_parser; no dependencies
`default_nettype none

package hbr_pkg;

	localparam int FIELD_BITS  = 63;
	localparam int OFFSET_BITS = 63;

	localparam logic [2:0] PREFIX_LEN = 3'd6;

	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	typedef enum logic [2:0] {
		ST_EMPTY = 3'd0,
		ST_SPACE = 3'd1,
		ST_PLUS  = 3'd2,
		ST_MINUS = 3'd3,
		ST_POS   = 3'd4,
		ST_NEGZ  = 3'd5,
		ST_BAD   = 3'd6
	} num_st_t;

	typedef struct packed {
		num_st_t                st;
		logic [OFFSET_BITS-1:0] val;
	} num_rd_t;

	// header summary handed from the parser to the result stage
	typedef struct packed {
		logic                   ok_pre;
		logic                   suffix_form;
		num_rd_t                left;
		num_rd_t                right;
		logic [OFFSET_BITS-1:0] size;
	} hbr_snap_t;

	function automatic logic [7:0] prefix_char(logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0:    ch = 8'h62;
			3'd1:    ch = 8'h79;
			3'd2:    ch = 8'h74;
			3'd3:    ch = 8'h65;
			3'd4:    ch = 8'h73;
			default: ch = 8'h3d;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] to_lower(logic [7:0] c);
		logic [7:0] lc;
		lc = (c inside {[8'h41:8'h5a]}) ? c + 8'd32 : c;
		return lc;
	endfunction

	function automatic logic is_space(logic [7:0] c);
		logic r;
		r = (c == 8'h20) || (c inside {[8'h09:8'h0d]});
		return r;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		logic r;
		r = c inside {[8'h30:8'h39]};
		return r;
	endfunction

	function automatic logic num_ok(num_st_t st);
		logic r;
		r = (st == ST_POS) || (st == ST_NEGZ);
		return r;
	endfunction

	// one character step of a decimal reader with sign and whitespace leniency
	function automatic num_rd_t num_feed(num_rd_t cur, logic [7:0] c);
		num_rd_t              nxt;
		logic [3:0]           d;
		logic [OFFSET_BITS+3:0] acc;
		nxt = cur;
		d   = c[3:0];
		acc = ({4'b0, cur.val} << 3) + ({4'b0, cur.val} << 1) + {{OFFSET_BITS{1'b0}}, d};
		case (cur.st)
			ST_EMPTY, ST_SPACE: begin
				if (is_space(c)) begin
					nxt.st = ST_SPACE;
				end else if (c == CH_PLUS) begin
					nxt.st = ST_PLUS;
				end else if (c == CH_DASH) begin
					nxt.st = ST_MINUS;
				end else if (is_digit(c)) begin
					nxt.st  = ST_POS;
					nxt.val = OFFSET_BITS'(d);
				end else begin
					nxt.st = ST_BAD;
				end
			end
			ST_PLUS: begin
				if (is_digit(c)) begin
					nxt.st  = ST_POS;
					nxt.val = OFFSET_BITS'(d);
				end else begin
					nxt.st = ST_BAD;
				end
			end
			ST_MINUS, ST_NEGZ: begin
				nxt.st  = (c == CH_ZERO) ? ST_NEGZ : ST_BAD;
				nxt.val = '0;
			end
			ST_POS: begin
				if (is_digit(c) && (acc[OFFSET_BITS+3:OFFSET_BITS] == 4'b0)) begin
					nxt.val = acc[OFFSET_BITS-1:0];
				end else begin
					nxt.st = ST_BAD;
				end
			end
			default: begin
				nxt.st = ST_BAD;
			end
		endcase
		return nxt;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/http_byte_range_parser.sv =====
// after its last character is accepted, a result is registered in the summary register, then in the output register
// throughput: one character per cycle; the input stalls only when a last character meets
// a full summary register whose result is held by a stalled output
// reset: arst_n clears the input, summary and output valids and all parser state at once
// input register, then hbr_parse (character state), then hbr_resolve (range result)
// depends on hbr_pkg, hbr_parse, hbr_resolve
`default_nettype none

module http_byte_range_parser import hbr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            header_byte,
	input  wire logic                  is_last,
	input  wire logic [FIELD_BITS-1:0] resource_size,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       range_ok,
	output logic [FIELD_BITS-1:0]      first_offset,
	output logic [FIELD_BITS-1:0]      last_offset
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;
	logic [FIELD_BITS-1:0] size_s1;
	logic                  take;
	logic                  snap_valid;
	logic                  snap_ready;
	hbr_snap_t             snap;

	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= header_byte;
			last_s1 <= is_last;
			size_s1 <= resource_size;
		end
	end

	hbr_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item_byte  (byte_s1),
		.item_last  (last_s1),
		.item_size  (size_s1),
		.take       (take),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap)
	);

	hbr_resolve u_resolve (
		.clk          (clk),
		.arst_n       (arst_n),
		.snap_valid   (snap_valid),
		.snap_ready   (snap_ready),
		.snap         (snap),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.range_ok     (range_ok),
		.first_offset (first_offset),
		.last_offset  (last_offset)
	);

`ifndef NO_ASSERTIONS
	a_stall_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && last_s1 && snap_valid))
		else $error("input stalled without a blocked last item");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !range_ok) |-> (first_offset == '0 && last_offset == '0))
		else $error("rejected result carries nonzero offsets");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && range_ok) |-> (first_offset <= last_offset))
		else $error("accepted range has first above last");

	a_snap_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(snap_valid && !out_valid) |=> out_valid)
		else $error("summary not moved into an empty output register");
`endif

endmodule

`default_nettype wire

// ===== rtl/hbr_parse.sv =====
// hbr_parse: per-character header state (prefix match, dash split, two number readers)
// loads a summary register on the last character; depends on hbr_pkg
`default_nettype none

module hbr_parse import hbr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	input  wire logic [7:0]            item_byte,
	input  wire logic                  item_last,
	input  wire logic [FIELD_BITS-1:0] item_size,
	output logic                       take,
	output logic                       snap_valid,
	input  wire logic                  snap_ready,
	output hbr_snap_t                  snap
);

	logic [2:0] prefix_cnt_q, prefix_cnt_n;
	logic       after_dash_q, after_dash_n;
	logic       suffix_q, suffix_n;
	logic       rejected_q, rejected_n;
	num_rd_t    left_q, left_n;
	num_rd_t    right_q, right_n;
	logic       snap_valid_q;
	hbr_snap_t  snap_q;
	logic [OFFSET_BITS-1:0] size_m;

	assign size_m = item_size[OFFSET_BITS-1:0];
	assign take   = item_valid && !(item_last && snap_valid_q && !snap_ready);

	always_comb begin
		prefix_cnt_n = prefix_cnt_q;
		after_dash_n = after_dash_q;
		suffix_n     = suffix_q;
		rejected_n   = rejected_q;
		left_n       = left_q;
		right_n      = right_q;
		if (prefix_cnt_q < PREFIX_LEN) begin
			if (to_lower(item_byte) != prefix_char(prefix_cnt_q)) begin
				rejected_n = 1'b1;
			end
			prefix_cnt_n = prefix_cnt_q + 3'd1;
		end else if (item_byte == CH_COMMA) begin
			rejected_n = 1'b1;
		end else if (!after_dash_q && item_byte == CH_DASH) begin
			after_dash_n = 1'b1;
			suffix_n     = (left_q.st == ST_EMPTY);
		end else if (!after_dash_q) begin
			left_n = num_feed(left_q, item_byte);
		end else begin
			right_n = num_feed(right_q, item_byte);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_cnt_q <= '0;
			after_dash_q <= 1'b0;
			suffix_q     <= 1'b0;
			rejected_q   <= 1'b0;
			left_q       <= '{st: ST_EMPTY, val: '0};
			right_q      <= '{st: ST_EMPTY, val: '0};
		end else if (take) begin
			if (item_last) begin
				prefix_cnt_q <= '0;
				after_dash_q <= 1'b0;
				suffix_q     <= 1'b0;
				rejected_q   <= 1'b0;
				left_q       <= '{st: ST_EMPTY, val: '0};
				right_q      <= '{st: ST_EMPTY, val: '0};
			end else begin
				prefix_cnt_q <= prefix_cnt_n;
				after_dash_q <= after_dash_n;
				suffix_q     <= suffix_n;
				rejected_q   <= rejected_n;
				left_q       <= left_n;
				right_q      <= right_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_q <= 1'b0;
		end else if (take && item_last) begin
			snap_valid_q <= 1'b1;
		end else if (snap_ready) begin
			snap_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_last) begin
			snap_q.ok_pre      <= !rejected_n && (prefix_cnt_n == PREFIX_LEN) && after_dash_n
				&& (size_m != '0);
			snap_q.suffix_form <= suffix_n;
			snap_q.left        <= left_n;
			snap_q.right       <= right_n;
			snap_q.size        <= size_m;
		end
	end

	assign snap_valid = snap_valid_q;
	assign snap       = snap_q;

endmodule

`default_nettype wire

// ===== rtl/hbr_resolve.sv =====
// hbr_resolve: turns a header summary into the range result and holds the output register
// depends on hbr_pkg
`default_nettype none

module hbr_resolve import hbr_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   snap_valid,
	output logic                        snap_ready,
	input  wire hbr_snap_t              snap,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        range_ok,
	output logic [FIELD_BITS-1:0]       first_offset,
	output logic [FIELD_BITS-1:0]       last_offset
);

	logic                   out_valid_q;
	logic                   ok_q;
	logic [FIELD_BITS-1:0]  first_q, last_q;

	logic                   ok_c;
	logic [OFFSET_BITS-1:0] first_c, last_c;
	logic [OFFSET_BITS-1:0] size_m1, diff;
	logic                   l_ok, r_ok, r_gt_size, l_lt_size, r_lt_l;

	assign snap_ready = !out_valid_q || !out_stall;

	assign size_m1   = snap.size - OFFSET_BITS'(1);
	assign diff      = snap.size - snap.right.val;
	assign l_ok      = num_ok(snap.left.st);
	assign r_ok      = num_ok(snap.right.st);
	assign r_gt_size = snap.right.val > snap.size;
	assign l_lt_size = snap.left.val < snap.size;
	assign r_lt_l    = snap.right.val < snap.left.val;

	always_comb begin
		ok_c    = snap.ok_pre;
		first_c = '0;
		last_c  = '0;
		if (snap.suffix_form) begin
			if (!r_ok || snap.right.val == '0) begin
				ok_c = 1'b0;
			end else begin
				first_c = r_gt_size ? '0 : diff;
				last_c  = size_m1;
			end
		end else begin
			if (!l_ok || !l_lt_size) begin
				ok_c = 1'b0;
			end else if (snap.right.st == ST_EMPTY) begin
				first_c = snap.left.val;
				last_c  = size_m1;
			end else if (!r_ok || r_lt_l) begin
				ok_c = 1'b0;
			end else begin
				first_c = snap.left.val;
				last_c  = (snap.right.val >= snap.size) ? size_m1 : snap.right.val;
			end
		end
		if (!ok_c) begin
			first_c = '0;
			last_c  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (snap_valid && snap_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && snap_ready) begin
			ok_q    <= ok_c;
			first_q <= FIELD_BITS'(first_c);
			last_q  <= FIELD_BITS'(last_c);
		end
	end

	assign out_valid    = out_valid_q;
	assign range_ok     = ok_q;
	assign first_offset = first_q;
	assign last_offset  = last_q;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// tb: self-checking bench for http_byte_range_parser, directed headers then random ones
// predicts each range result from the bytes it sees accepted (pinned directed rows use their table result instead)
// and compares at the output; depends on hbr_pkg and the parser rtl
`default_nettype none

module tb;
	import hbr_pkg::*;

	localparam logic [62:0] TOP_SIZE    = {63{1'b1}};
	localparam logic [47:0] PFX_TEXT    = "bytes=";
	localparam int          RAND_BYTES  = 740;
	localparam int          HOLD_CYCLES = 400;
	localparam int          CYCLE_LIMIT = 300000;

	typedef struct packed {
		num_st_t     st;
		logic [62:0] val;
	} dec_rd_t;

	typedef struct packed {
		logic        ok;
		logic [62:0] lo;
		logic [62:0] hi;
	} range_res_t;

	typedef struct {
		logic [7:0]  ch;
		logic        last;
		logic [62:0] rsize;
		bit          pinned;
		range_res_t  want;
	} hdr_item_t;

	typedef struct {
		string       text;
		logic [62:0] rsize;
		int          poke_at;
		logic [7:0]  poke_val;
		bit          pinned;
		logic        ok;
		logic [62:0] lo;
		logic [62:0] hi;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  header_byte = 8'h00;
	logic        is_last = 1'b0;
	logic [62:0] resource_size = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        range_ok;
	logic [62:0] first_offset;
	logic [62:0] last_offset;

	// predictor state
	logic [2:0]  pfx_seen = '0;
	logic        split_seen = 1'b0;
	logic        suffix_mode = 1'b0;
	logic        bad_hdr = 1'b0;
	dec_rd_t     lhs = '0;
	dec_rd_t     rhs = '0;

	logic [7:0]  hdr_buf [$];
	hdr_item_t   feed_q [$];
	range_res_t  range_q [$];
	hdr_item_t   cur_item;
	range_res_t  pred_res;
	range_res_t  got_res;

	bit          in_fire = 1'b0;
	bit          quiet = 1'b0;
	int          quiet_left = 0;
	int          taken_items = 0;
	int          stim_total = 0;
	int          headers_seen = 0;
	int          results_seen = 0;
	int          ok_seen = 0;
	int          mismatches = 0;
	int          cycles = 0;

	dir_row_t dir_tab [0:26] = '{
		'{"bytes=0-99",                  63'd1000, -1, 8'h00, 1, 1'b1, 63'd0, 63'd99},
		'{"BYTES=10-",                   63'd100,  -1, 8'h00, 1, 1'b1, 63'd10, 63'd99},
		'{"bYtEs=-5",                    63'd100,  -1, 8'h00, 1, 1'b1, 63'd95, 63'd99},
		'{"bytes=-500",                  63'd100,  -1, 8'h00, 1, 1'b1, 63'd0, 63'd99},
		'{"bytes=-1",                    TOP_SIZE, -1, 8'h00, 1, 1'b1, TOP_SIZE - 1,
			TOP_SIZE - 1},
		'{"bytes=0-9223372036854775807", TOP_SIZE, -1, 8'h00, 1, 1'b1, 63'd0, TOP_SIZE - 1},
		'{"bytes=9223372036854775806-",  TOP_SIZE, -1, 8'h00, 1, 1'b1, TOP_SIZE - 1,
			TOP_SIZE - 1},
		'{"bytes=9223372036854775807-",  TOP_SIZE, -1, 8'h00, 1, 1'b0, 63'd0, 63'd0},
		'{"bytes=9223372036854775808-",  TOP_SIZE, -1, 8'h00, 1, 1'b0, 63'd0, 63'd0},
		'{"bytes=0-0",                   63'd0,    -1, 8'h00, 1, 1'b0, 63'd0, 63'd0},
		'{"bytes=0-1,2-3",               63'd100,  -1, 8'h00, 1, 1'b0, 63'd0, 63'd0},
		'{"bytes=",                      63'd100,  -1, 8'h00, 1, 1'b0, 63'd0, 63'd0},
		'{"byt",                         63'd100,  -1, 8'h00, 1, 1'b0, 63'd0, 63'd0},
		'{"-",                           63'd100,  -1, 8'h00, 1, 1'b0, 63'd0, 63'd0},
		'{"bytes= \t+7-\0158",           63'd100,  -1, 8'h00, 1, 1'b1, 63'd7, 63'd8},
		'{"bytes=-0",                    63'd100,  -1, 8'h00, 1, 1'b0, 63'd0, 63'd0},
		'{"bytes=0--00",                 63'd10,   -1, 8'h00, 1, 1'b1, 63'd0, 63'd0},
		'{"bytes=5-3",                   63'd100,  -1, 8'h00, 1, 1'b0, 63'd0, 63'd0},
		'{"bytes=5-",                    63'd5,    -1, 8'h00, 1, 1'b0, 63'd0, 63'd0},
		'{"bytes=5-1000",                63'd10,   -1, 8'h00, 1, 1'b1, 63'd5, 63'd9},
		'{"bytes=5x-9",                  63'd100,  -1, 8'h00, 1, 1'b0, 63'd0, 63'd0},
		'{"bytes=5-9 ",                  63'd100,  -1, 8'h00, 1, 1'b0, 63'd0, 63'd0},
		'{"bytes=1-2",                   63'd100,   8, 8'h00, 1, 1'b0, 63'd0, 63'd0},
		'{"bytes=1-2",                   63'd100,   0, 8'hff, 1, 1'b0, 63'd0, 63'd0},
		'{"bytes=--5",                   63'd100,  -1, 8'h00, 1, 1'b0, 63'd0, 63'd0},
		'{"bytes=17-4000",               63'd1234, -1, 8'h00, 0, 1'b0, 63'd0, 63'd0},
		'{"Bytes=\t 42-",                63'd600,  -1, 8'h00, 0, 1'b0, 63'd0, 63'd0}
	};

	http_byte_range_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.header_byte  (header_byte),
		.is_last      (is_last),
		.resource_size(resource_size),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.range_ok     (range_ok),
		.first_offset (first_offset),
		.last_offset  (last_offset)
	);

	always #5 clk = ~clk;

	function automatic logic dec_done(num_st_t st);
		return (st == ST_POS) || (st == ST_NEGZ);
	endfunction

	// one character into a decimal reader
	function automatic dec_rd_t dec_step(dec_rd_t r, logic [7:0] c);
		dec_rd_t     n;
		logic        dig;
		logic        sp;
		logic [66:0] wide;
		n    = r;
		dig  = (c >= 8'h30) && (c <= 8'h39);
		sp   = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
		wide = {4'b0, r.val} * 67'd10 + 67'(c[3:0]);
		case (r.st)
			ST_EMPTY, ST_SPACE: begin
				if (sp) begin
					n.st = ST_SPACE;
				end else if (c == CH_PLUS) begin
					n.st = ST_PLUS;
				end else if (c == CH_DASH) begin
					n.st = ST_MINUS;
				end else if (dig) begin
					n.st  = ST_POS;
					n.val = 63'(c[3:0]);
				end else begin
					n.st = ST_BAD;
				end
			end
			ST_PLUS: begin
				if (dig) begin
					n.st  = ST_POS;
					n.val = 63'(c[3:0]);
				end else begin
					n.st = ST_BAD;
				end
			end
			ST_MINUS, ST_NEGZ: begin
				n.st  = (c == CH_ZERO) ? ST_NEGZ : ST_BAD;
				n.val = '0;
			end
			ST_POS: begin
				if (!dig || wide > {4'b0, TOP_SIZE}) begin
					n.st = ST_BAD;
				end else begin
					n.val = wide[62:0];
				end
			end
			default: begin
				n.st = ST_BAD;
			end
		endcase
		return n;
	endfunction

	// advances the parser model by one character, returns 1 when a range result is due
	function automatic bit range_step(logic [7:0] c, logic last, logic [62:0] rsize,
		output range_res_t res);
		logic [7:0] lc;
		logic       ok;
		res = '0;
		if (pfx_seen < PREFIX_LEN) begin
			lc = ((c >= 8'h41) && (c <= 8'h5a)) ? c + 8'd32 : c;
			if (lc != PFX_TEXT[47 - 8 * pfx_seen -: 8]) begin
				bad_hdr = 1'b1;
			end
			pfx_seen = pfx_seen + 3'd1;
		end else if (c == CH_COMMA) begin
			bad_hdr = 1'b1;
		end else if (!split_seen && c == CH_DASH) begin
			split_seen  = 1'b1;
			suffix_mode = (lhs.st == ST_EMPTY);
		end else if (!split_seen) begin
			lhs = dec_step(lhs, c);
		end else begin
			rhs = dec_step(rhs, c);
		end
		if (!last) begin
			return 1'b0;
		end
		ok = !bad_hdr && (pfx_seen == PREFIX_LEN) && split_seen && (rsize != '0);
		if (ok && suffix_mode) begin
			if (!dec_done(rhs.st) || rhs.val == '0) begin
				ok = 1'b0;
			end else begin
				res.lo = rsize - ((rhs.val > rsize) ? rsize : rhs.val);
				res.hi = rsize - 63'd1;
			end
		end else if (ok) begin
			if (!dec_done(lhs.st) || lhs.val >= rsize) begin
				ok = 1'b0;
			end else if (rhs.st == ST_EMPTY) begin
				res.lo = lhs.val;
				res.hi = rsize - 63'd1;
			end else if (!dec_done(rhs.st) || rhs.val < lhs.val) begin
				ok = 1'b0;
			end else begin
				res.lo = lhs.val;
				res.hi = (rhs.val >= rsize) ? rsize - 63'd1 : rhs.val;
			end
		end
		if (!ok) begin
			res = '0;
		end
		res.ok      = ok;
		pfx_seen    = '0;
		split_seen  = 1'b0;
		suffix_mode = 1'b0;
		bad_hdr     = 1'b0;
		lhs         = '0;
		rhs         = '0;
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [62:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) begin
			return '0;
		end else if (r < 12) begin
			return TOP_SIZE;
		end else if (r < 28) begin
			return 63'({$urandom, $urandom});
		end else if (r < 34) begin
			return 63'($urandom_range(1, 3));
		end
		return 63'($urandom_range(1, 5000));
	endfunction

	function automatic logic [62:0] pick_value(logic [62:0] rsize);
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 63'($urandom_range(0, 6000));
		end else if (r < 60) begin
			return (rsize > 63'd3) ? rsize - 63'($urandom_range(0, 3)) :
				63'($urandom_range(0, 3));
		end else if (r < 72) begin
			return 63'({$urandom, $urandom});
		end else if (r < 82) begin
			return TOP_SIZE - 63'($urandom_range(0, 2));
		end
		return 63'($urandom_range(0, 9));
	endfunction

	function automatic void push_text(string s);
		int k;
		for (k = 0; k < s.len(); k++) begin
			hdr_buf.push_back(s[k]);
		end
	endfunction

	// decorated decimal text: whitespace, sign, leading zeros, overflow and trailing junk
	function automatic void push_number(logic [62:0] v);
		int r;
		int k;
		if ($urandom_range(0, 99) < 12) begin
			for (k = $urandom_range(1, 2); k > 0; k--) begin
				r = $urandom_range(0, 5);
				hdr_buf.push_back((r == 0) ? 8'h20 : 8'(8 + r));
			end
		end
		r = $urandom_range(0, 99);
		if (r < 8) begin
			hdr_buf.push_back(CH_PLUS);
		end else if (r < 15) begin
			hdr_buf.push_back(CH_DASH);
			if ($urandom_range(0, 3) != 0) begin
				v = '0;
			end
		end
		if ($urandom_range(0, 99) < 8) begin
			push_text("00");
		end
		if ($urandom_range(0, 99) < 3) begin
			push_text("9223372036854775808");
		end else begin
			push_text($sformatf("%0d", v));
		end
		if ($urandom_range(0, 99) < 5) begin
			hdr_buf.push_back(CH_ZERO);
		end
		if ($urandom_range(0, 99) < 4) begin
			hdr_buf.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	function automatic void emit_header(logic [62:0] rsize, bit pinned, range_res_t want);
		hdr_item_t it;
		foreach (hdr_buf[k]) begin
			it.ch     = hdr_buf[k];
			it.last   = (k == hdr_buf.size() - 1);
			it.rsize  = it.last ? rsize : 63'({$urandom, $urandom});
			it.pinned = pinned;
			it.want   = want;
			feed_q.push_back(it);
		end
		hdr_buf.delete();
	endfunction

	function automatic void build_random();
		int          r;
		int          k;
		int          form;
		logic [7:0]  c;
		logic [62:0] rsize;
		logic [62:0] s;
		logic [62:0] e;
		hdr_buf.delete();
		r     = $urandom_range(0, 99);
		rsize = pick_size();
		if (r < 8) begin
			for (k = $urandom_range(1, 12); k > 0; k--) begin
				hdr_buf.push_back(8'($urandom_range(0, 255)));
			end
		end else begin
			for (k = 0; k < 6; k++) begin
				c = PFX_TEXT[47 - 8 * k -: 8];
				if (c != 8'h3d && $urandom_range(0, 3) == 0) begin
					c = c - 8'd32;
				end
				hdr_buf.push_back(c);
			end
			if (r < 12) begin
				k = $urandom_range(1, 6);
				while (hdr_buf.size() > k) begin
					void'(hdr_buf.pop_back());
				end
			end else begin
				form = $urandom_range(0, 2);
				s    = pick_value(rsize);
				if ($urandom_range(0, 1) == 0) begin
					e = (s > TOP_SIZE - 63'd300) ? TOP_SIZE : s + 63'($urandom_range(0, 300));
				end else begin
					e = pick_value(rsize);
				end
				if (form == 0) begin
					hdr_buf.push_back(CH_DASH);
					push_number(s);
				end else begin
					push_number(s);
					hdr_buf.push_back(CH_DASH);
					if (form == 2) begin
						push_number(e);
					end
				end
				if ($urandom_range(0, 99) < 4) begin
					hdr_buf.insert($urandom_range(6, hdr_buf.size()), CH_COMMA);
				end
				if ($urandom_range(0, 99) < 6) begin
					hdr_buf[$urandom_range(0, hdr_buf.size() - 1)] = 8'($urandom_range(0, 255));
				end
			end
		end
		emit_header(rsize, 1'b0, '0);
	endfunction

	task automatic flag_mismatch(string what, logic [62:0] got, logic [62:0] want);
		mismatches++;
		if (mismatches <= 40) begin
			$display("mismatch on %s: got %0d, expected %0d (result %0d, cycle %0d)",
				what, got, want, results_seen, cycles);
		end
	endtask

	// output check first, then prediction of the item taken at this edge
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (range_q.size() == 0) begin
				flag_mismatch("result with none pending", first_offset, '0);
			end else begin
				got_res = range_q.pop_front();
				if (range_ok !== got_res.ok) begin
					flag_mismatch("range_ok", 63'(range_ok), 63'(got_res.ok));
				end
				if (first_offset !== got_res.lo) begin
					flag_mismatch("first_offset", first_offset, got_res.lo);
				end
				if (last_offset !== got_res.hi) begin
					flag_mismatch("last_offset", last_offset, got_res.hi);
				end
				if (got_res.ok) begin
					ok_seen++;
				end
			end
			results_seen++;
		end
		in_fire = in_valid && !in_stall;
		if (in_fire) begin
			taken_items++;
			if (range_step(header_byte, is_last, resource_size, pred_res)) begin
				range_q.push_back(cur_item.pinned ? cur_item.want : pred_res);
				headers_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (quiet_left == 0) begin
			quiet      <= !quiet;
			quiet_left <= $urandom_range(50, 300);
		end else begin
			quiet_left <= quiet_left - 1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout with %0d results pending", range_q.size());
			$display("[http_byte_range_parser] ERROR");
			$finish;
		end
	end

	initial begin : sender
		int gap;
		gap = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (in_valid && !in_fire) begin
				// stalled item stays put
			end else if (gap > 0) begin
				in_valid <= 1'b0;
				gap--;
			end else if (feed_q.size() > 0) begin
				cur_item = feed_q.pop_front();
				header_byte   <= cur_item.ch;
				is_last       <= cur_item.last;
				resource_size <= cur_item.rsize;
				in_valid      <= 1'b1;
				gap = quiet ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	initial begin : receiver
		int hold;
		int pause;
		bit held;
		hold  = 0;
		pause = 0;
		held  = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else if (!held && results_seen >= 40) begin
				// long hold-off so the pipeline fills and backs up the input
				held = 1'b1;
				hold = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (pause > 0) begin
				out_stall <= 1'b1;
				pause--;
			end else begin
				out_stall <= 1'b0;
				pause = quiet ? 0 : pick_gap();
			end
		end
	end

	initial begin : main
		int dir_bytes;
		range_res_t want;
		foreach (dir_tab[i]) begin
			push_text(dir_tab[i].text);
			if (dir_tab[i].poke_at >= 0) begin
				hdr_buf[dir_tab[i].poke_at] = dir_tab[i].poke_val;
			end
			want = '{dir_tab[i].ok, dir_tab[i].lo, dir_tab[i].hi};
			emit_header(dir_tab[i].rsize, dir_tab[i].pinned, want);
		end
		dir_bytes = feed_q.size();
		while (feed_q.size() < dir_bytes + RAND_BYTES) begin
			build_random();
		end
		stim_total = feed_q.size();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait (taken_items == stim_total && range_q.size() == 0);
		repeat (12) @(posedge clk);
		$display("%0d headers over %0d characters, %0d ranges satisfiable, %0d rejected",
			headers_seen, taken_items, ok_seen, results_seen - ok_seen);
		$display("checked %0d results with %0d mismatches", results_seen, mismatches);
		if (mismatches == 0 && range_q.size() == 0) begin
			$display("[http_byte_range_parser] OK");
		end else begin
			$display("[http_byte_range_parser] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/hbr_pkg.sv
rtl/hbr_parse.sv
rtl/hbr_resolve.sv
rtl/http_byte_range_parser.sv
sim/tb.sv
